/* sv/plt_pkg.sv */
// shared types, constants and codes for the peer lease table
package plt_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int MAX_MEMBERS = 8;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int NODE_W      = 16;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    // frame constants
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [3:0] FRAME_VER = 4'd4;
    localparam int         PART_BIT  = 1;   // bit of byte 2 that holds 0x02

    // input kinds
    localparam logic [1:0] KIND_HB    = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // result status codes
    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_BAD     = 3'd1;
    localparam logic [2:0] ST_REFUSED = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_TICK    = 3'd4;
    localparam logic [2:0] ST_QUERY   = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_LOCAL     = 3'd0;
    localparam logic [2:0] CFG_PREFERRED = 3'd1;
    localparam logic [2:0] CFG_FPRINT    = 3'd2;
    localparam logic [2:0] CFG_LEASE     = 3'd3;
    localparam logic [2:0] CFG_MEMBERS_A = 3'd4;
    localparam logic [2:0] CFG_MEMBERS_B = 3'd5;
    localparam logic [2:0] CFG_SWARM     = 3'd6;
    localparam logic [2:0] CFG_PART      = 3'd7;

    typedef logic [MAX_MEMBERS-1:0][NODE_W-1:0] t_members;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] peer;
        logic [15:0]       swarm;
        logic              joined;
        logic [15:0]       lease;
    } t_slot;

    typedef enum logic [1:0] {
        OP_SCAN,
        OP_WRITE,
        OP_TICK,
        OP_QUERY
    } t_op;

    typedef struct packed {
        logic              step;
        t_op               op;
        logic [SLOT_W-1:0] idx;
        logic [SLOT_W-1:0] target;
    } t_walk_ctrl;

    typedef struct packed {
        logic [NODE_W-1:0] local_num;
        logic [NODE_W-1:0] preferred;
        t_members          members;
        logic [15:0]       own_swarm;
        logic              own_part;
    } t_walk_cfg;

    typedef struct packed {
        logic                   match_found;
        logic [SLOT_W-1:0]      match_idx;
        logic                   free_found;
        logic [SLOT_W-1:0]      free_idx;
        logic                   pref_present;
        logic [MAX_MEMBERS-1:0] member_present;
        logic [NODE_W-1:0]      min_peer;
        logic                   accepted;
    } t_walk_acc;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_PLACE,
        S_WRITE,
        S_TICK,
        S_SEL,
        S_QUERY
    } t_state;

endpackage

/* sv/plt_cell.sv */
// one table slot in the rotating chain
module plt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  plt_pkg::t_slot i_slot,
    output plt_pkg::t_slot o_slot
);

    logic                       r_valid;
    logic [plt_pkg::NODE_W-1:0] r_peer;
    logic [15:0]                r_swarm;
    logic                       r_joined;
    logic [15:0]                r_lease;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_slot.valid;
        end
    end

    // payload carries no reset, only read while valid
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_peer   <= i_slot.peer;
            r_swarm  <= i_slot.swarm;
            r_joined <= i_slot.joined;
            r_lease  <= i_slot.lease;
        end
    end

    assign o_slot = '{valid: r_valid, peer: r_peer, swarm: r_swarm, joined: r_joined,
                      lease: r_lease};

endmodule

/* sv/plt_walker.sv */
// head of the chain: updates the passing slot and gathers scan results
module plt_walker (
    input  logic                 i_clk,
    input  plt_pkg::t_walk_ctrl  i_ctrl,
    input  plt_pkg::t_walk_cfg   i_cfg,
    input  logic [15:0]          i_src,
    input  plt_pkg::t_slot       i_new,
    input  plt_pkg::t_slot       i_slot,
    output plt_pkg::t_slot       o_slot,
    output plt_pkg::t_walk_acc   o_acc
);

    plt_pkg::t_walk_acc r_acc;
    plt_pkg::t_walk_acc n_acc;
    plt_pkg::t_walk_acc w_base;

    // accumulators restart on the first slot of every walk
    always_comb begin
        w_base = r_acc;
        if (i_ctrl.idx == '0) begin
            w_base = '0;
            w_base.min_peer = i_cfg.local_num;
        end
    end

    always_comb begin
        o_slot = i_slot;
        case (i_ctrl.op)
            plt_pkg::OP_TICK: begin
                if (i_slot.valid) begin
                    if (i_slot.lease != 16'd0) begin
                        o_slot.lease = i_slot.lease - 16'd1;
                    end
                    o_slot.valid = (o_slot.lease != 16'd0);
                end
            end
            plt_pkg::OP_WRITE: begin
                if (i_ctrl.idx == i_ctrl.target) begin
                    o_slot = i_new;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_acc = w_base;
        case (i_ctrl.op)
            plt_pkg::OP_SCAN: begin
                if (i_slot.valid && i_slot.peer == i_src && !w_base.match_found) begin
                    n_acc.match_found = 1'b1;
                    n_acc.match_idx   = i_ctrl.idx;
                end
                if (!i_slot.valid && !w_base.free_found) begin
                    n_acc.free_found = 1'b1;
                    n_acc.free_idx   = i_ctrl.idx;
                end
            end
            plt_pkg::OP_TICK: begin
                // presence is judged on the aged entry
                if (o_slot.valid) begin
                    if (o_slot.peer == i_cfg.preferred) begin
                        n_acc.pref_present = 1'b1;
                    end
                    for (int j = 0; j < plt_pkg::MAX_MEMBERS; j++) begin
                        if (o_slot.peer == i_cfg.members[j]) begin
                            n_acc.member_present[j] = 1'b1;
                        end
                    end
                    if (o_slot.peer < w_base.min_peer) begin
                        n_acc.min_peer = o_slot.peer;
                    end
                end
            end
            plt_pkg::OP_QUERY: begin
                if (i_cfg.own_part && i_slot.valid && i_slot.peer == i_src &&
                    i_slot.lease != 16'd0 && i_slot.joined &&
                    i_slot.swarm == i_cfg.own_swarm) begin
                    n_acc.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

/* sv/peer_lease_table_leader_select.sv */
// top level: configuration, sequencer and slot chain of the peer lease table
//
// usage
// - command channel: drive i_kind, i_source, i_frame and raise i_start; the
//   word is taken at a clock edge where i_start is high and o_busy is low
// - result channel: o_done is high for exactly one cycle with o_status,
//   o_active_node, o_local_active, o_active_changed and o_payload_accepted;
//   the receiver cannot stall, the word must be taken in that cycle
// - configuration channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; ready is always high, write only while the block is idle
// - from accept to o_done: a bad or refused heartbeat or an unknown kind
//   ends after the check state, a query after one walk of the table, a tick
//   after one walk and the select state, a stored or full heartbeat after
//   one scan walk to find the sender or a free slot, then, if stored, one
//   write walk; one word at a time, as the chain of slot cells rotates one
//   slot per cycle past the single head unit in a walk
// - a new command may be taken in the same cycle o_done is high
// - reset: all slots empty, registers at their reset values, active node
//   set to the initial candidate (node 1)
module peer_lease_table_leader_select (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_source,
    input  logic [63:0] i_frame,
    // result channel
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_active_node,
    output logic        o_local_active,
    output logic        o_active_changed,
    output logic        o_payload_accepted,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // configuration registers
    logic [15:0] r_local;
    logic [15:0] r_pref;
    logic [23:0] r_fprint;
    logic [15:0] r_lease;
    logic [63:0] r_mem_a;
    logic [63:0] r_mem_b;
    logic [15:0] r_swarm;
    logic        r_part;

    logic [15:0] n_local;
    logic [15:0] n_pref;
    logic [63:0] n_mem_a;
    logic        w_cfg_wr;
    logic        w_reinit;
    logic [15:0] w_candidate;

    // sequencer state
    plt_pkg::t_state           r_state;
    plt_pkg::t_state           n_state;
    logic [plt_pkg::SLOT_W-1:0] r_cnt;
    logic [plt_pkg::SLOT_W-1:0] n_cnt;
    logic [plt_pkg::SLOT_W-1:0] r_target;
    logic [1:0]                r_kind;
    logic [15:0]               r_src;
    logic [63:0]               r_frame;
    logic [15:0]               r_active;

    // result registers
    logic        r_done;
    logic [2:0]  r_status;
    logic [15:0] r_out_active;
    logic        r_out_local;
    logic        r_out_changed;
    logic        r_out_accepted;

    // sequencer outputs
    logic        w_accept;
    logic        w_walking;
    logic        w_last;
    logic        w_fin;
    logic [2:0]  w_fin_status;
    logic        w_load_target;
    plt_pkg::t_op w_op;

    // chain and head
    plt_pkg::t_slot      w_cell_q [plt_pkg::TABLE_SLOTS];
    plt_pkg::t_slot      w_feed;
    plt_pkg::t_slot      w_new;
    plt_pkg::t_walk_ctrl w_ctrl;
    plt_pkg::t_walk_cfg  w_wcfg;
    plt_pkg::t_walk_acc  w_acc;
    plt_pkg::t_members   w_members;

    // frame checks
    logic        w_bad;
    logic        w_refused;
    logic        w_in_list;
    logic        w_stop;
    logic [15:0] w_sel;
    logic        w_sel_done;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;
    assign w_accept    = i_start & ~o_busy;
    assign o_busy      = (r_state != plt_pkg::S_IDLE);

    // member list unpacked from the two list registers
    always_comb begin
        for (int j = 0; j < plt_pkg::MAX_MEMBERS; j++) begin
            if (j < 4) begin
                w_members[j] = r_mem_a[16*(j%4) +: 16];
            end else begin
                w_members[j] = r_mem_b[16*(j%4) +: 16];
            end
        end
    end

    // register writes with their would-be values for the initial candidate
    always_comb begin
        n_local  = r_local;
        n_pref   = r_pref;
        n_mem_a  = r_mem_a;
        w_reinit = 1'b0;
        if (w_cfg_wr) begin
            case (i_cfg_index)
                plt_pkg::CFG_LOCAL: begin
                    n_local  = i_cfg_data[15:0];
                    w_reinit = 1'b1;
                end
                plt_pkg::CFG_PREFERRED: begin
                    n_pref   = i_cfg_data[15:0];
                    w_reinit = 1'b1;
                end
                plt_pkg::CFG_MEMBERS_A: begin
                    n_mem_a  = i_cfg_data;
                    w_reinit = 1'b1;
                end
                plt_pkg::CFG_MEMBERS_B: begin
                    w_reinit = 1'b1;
                end
                default: begin
                end
            endcase
        end
        // preferred first, then the head of the list, then ourselves
        if (n_pref != 16'd0) begin
            w_candidate = n_pref;
        end else if (n_mem_a[15:0] != 16'd0) begin
            w_candidate = n_mem_a[15:0];
        end else begin
            w_candidate = n_local;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local  <= 16'd1;
            r_pref   <= 16'd0;
            r_fprint <= 24'd1;
            r_lease  <= 16'd30;
            r_mem_a  <= 64'd0;
            r_mem_b  <= 64'd0;
            r_swarm  <= 16'd1;
            r_part   <= 1'b0;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                plt_pkg::CFG_LOCAL:     r_local  <= i_cfg_data[15:0];
                plt_pkg::CFG_PREFERRED: r_pref   <= i_cfg_data[15:0];
                plt_pkg::CFG_FPRINT:    r_fprint <= i_cfg_data[23:0];
                plt_pkg::CFG_LEASE:     r_lease  <= i_cfg_data[15:0];
                plt_pkg::CFG_MEMBERS_A: r_mem_a  <= i_cfg_data;
                plt_pkg::CFG_MEMBERS_B: r_mem_b  <= i_cfg_data;
                plt_pkg::CFG_SWARM:     r_swarm  <= i_cfg_data[15:0];
                plt_pkg::CFG_PART:      r_part   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // heartbeat header checks and sender admission
    always_comb begin
        w_bad = (r_frame[7:0] != plt_pkg::CH_M) || (r_frame[15:8] != plt_pkg::CH_S) ||
                (r_frame[23:20] != plt_pkg::FRAME_VER) || (r_frame[47:24] != r_fprint) ||
                (r_frame[63:48] == 16'd0);
        w_in_list = 1'b0;
        w_stop    = 1'b0;
        for (int j = 0; j < plt_pkg::MAX_MEMBERS; j++) begin
            if (!w_stop) begin
                if (w_members[j] == 16'd0) begin
                    w_stop = 1'b1;
                end else if (w_members[j] == r_src) begin
                    w_in_list = 1'b1;
                    w_stop    = 1'b1;
                end
            end
        end
        w_refused = (r_src == 16'd0) || (r_src == r_local) ||
                    ((w_members[0] != 16'd0) && !w_in_list);
    end

    // active node selection from the gathered presence flags
    always_comb begin
        w_sel      = r_local;
        w_sel_done = 1'b0;
        if (r_pref != 16'd0 && (r_pref == r_local || w_acc.pref_present)) begin
            w_sel = r_pref;
        end else if (w_members[0] != 16'd0) begin
            for (int j = 0; j < plt_pkg::MAX_MEMBERS; j++) begin
                if (!w_sel_done) begin
                    if (w_members[j] == 16'd0) begin
                        w_sel_done = 1'b1;
                    end else if (w_members[j] == r_local || w_acc.member_present[j]) begin
                        w_sel      = w_members[j];
                        w_sel_done = 1'b1;
                    end
                end
            end
        end else begin
            w_sel = w_acc.min_peer;
        end
    end

    assign w_last = (r_cnt == plt_pkg::LAST_SLOT);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            plt_pkg::S_IDLE: begin
                if (w_accept) n_state = plt_pkg::S_CHECK;
            end
            plt_pkg::S_CHECK: begin
                case (r_kind)
                    plt_pkg::KIND_HB: begin
                        if (w_bad || w_refused) n_state = plt_pkg::S_IDLE;
                        else n_state = plt_pkg::S_SCAN;
                    end
                    plt_pkg::KIND_TICK:  n_state = plt_pkg::S_TICK;
                    plt_pkg::KIND_QUERY: n_state = plt_pkg::S_QUERY;
                    default:             n_state = plt_pkg::S_IDLE;
                endcase
            end
            plt_pkg::S_SCAN: begin
                if (w_last) n_state = plt_pkg::S_PLACE;
            end
            plt_pkg::S_PLACE: begin
                if (w_acc.match_found || w_acc.free_found) n_state = plt_pkg::S_WRITE;
                else n_state = plt_pkg::S_IDLE;
            end
            plt_pkg::S_WRITE: begin
                if (w_last) n_state = plt_pkg::S_IDLE;
            end
            plt_pkg::S_TICK: begin
                if (w_last) n_state = plt_pkg::S_SEL;
            end
            plt_pkg::S_SEL: begin
                n_state = plt_pkg::S_IDLE;
            end
            plt_pkg::S_QUERY: begin
                if (w_last) n_state = plt_pkg::S_IDLE;
            end
            default: begin
                n_state = plt_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_walking     = 1'b0;
        w_op          = plt_pkg::OP_SCAN;
        w_fin         = 1'b0;
        w_fin_status  = plt_pkg::ST_BAD;
        w_load_target = 1'b0;
        case (r_state)
            plt_pkg::S_CHECK: begin
                case (r_kind)
                    plt_pkg::KIND_HB: begin
                        if (w_bad) begin
                            w_fin = 1'b1;
                        end else if (w_refused) begin
                            w_fin        = 1'b1;
                            w_fin_status = plt_pkg::ST_REFUSED;
                        end
                    end
                    plt_pkg::KIND_TICK:  w_fin = 1'b0;
                    plt_pkg::KIND_QUERY: w_fin = 1'b0;
                    default:             w_fin = 1'b1;
                endcase
            end
            plt_pkg::S_SCAN: begin
                w_walking = 1'b1;
                w_op      = plt_pkg::OP_SCAN;
            end
            plt_pkg::S_PLACE: begin
                w_load_target = 1'b1;
                if (!(w_acc.match_found || w_acc.free_found)) begin
                    w_fin        = 1'b1;
                    w_fin_status = plt_pkg::ST_FULL;
                end
            end
            plt_pkg::S_WRITE: begin
                w_walking    = 1'b1;
                w_op         = plt_pkg::OP_WRITE;
                w_fin        = w_last;
                w_fin_status = plt_pkg::ST_STORED;
            end
            plt_pkg::S_TICK: begin
                w_walking = 1'b1;
                w_op      = plt_pkg::OP_TICK;
            end
            plt_pkg::S_SEL: begin
                w_fin        = 1'b1;
                w_fin_status = plt_pkg::ST_TICK;
            end
            plt_pkg::S_QUERY: begin
                w_walking    = 1'b1;
                w_op         = plt_pkg::OP_QUERY;
                w_fin        = w_last;
                w_fin_status = plt_pkg::ST_QUERY;
            end
            default: begin
            end
        endcase
    end

    // slot counter follows the rotation of the chain
    always_comb begin
        n_cnt = r_cnt;
        if (w_walking) begin
            n_cnt = w_last ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= plt_pkg::S_IDLE;
            r_cnt    <= '0;
            r_active <= 16'd1;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= w_fin;
            if (w_reinit) begin
                r_active <= w_candidate;
            end else if (r_state == plt_pkg::S_SEL) begin
                r_active <= w_sel;
            end
        end
    end

    // command word and result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_src   <= i_source;
            r_frame <= i_frame;
        end
        if (w_load_target) begin
            r_target <= w_acc.match_found ? w_acc.match_idx : w_acc.free_idx;
        end
        if (w_fin) begin
            r_status       <= w_fin_status;
            r_out_accepted <= (r_state == plt_pkg::S_QUERY) && w_acc.accepted;
            if (r_state == plt_pkg::S_SEL) begin
                r_out_active  <= w_sel;
                r_out_local   <= (w_sel == r_local);
                r_out_changed <= (w_sel != r_active);
            end else begin
                r_out_active  <= r_active;
                r_out_local   <= (r_active == r_local);
                r_out_changed <= 1'b0;
            end
        end
    end

    // at fin the query accumulator holds every slot but the last, so the last
    // slot is folded in live on the accepted path below
    plt_pkg::t_walk_acc w_acc_next;
    logic               w_q_accept;

    // head of the chain
    assign w_ctrl.step   = w_walking;
    assign w_ctrl.op     = w_op;
    assign w_ctrl.idx    = r_cnt;
    assign w_ctrl.target = r_target;

    assign w_wcfg.local_num = r_local;
    assign w_wcfg.preferred = r_pref;
    assign w_wcfg.members   = w_members;
    assign w_wcfg.own_swarm = r_swarm;
    assign w_wcfg.own_part  = r_part;

    assign w_new.valid  = 1'b1;
    assign w_new.peer   = r_src;
    assign w_new.swarm  = r_frame[63:48];
    assign w_new.joined = r_frame[16 + plt_pkg::PART_BIT];
    assign w_new.lease  = r_lease;

    plt_walker u_walker (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_cfg  (w_wcfg),
        .i_src  (r_src),
        .i_new  (w_new),
        .i_slot (w_cell_q[0]),
        .o_slot (w_feed),
        .o_acc  (w_acc)
    );

    // the last slot of a query walk is checked here, alongside the head
    assign w_acc_next = w_acc;
    assign w_q_accept = r_part && w_cell_q[0].valid && (w_cell_q[0].peer == r_src) &&
                        (w_cell_q[0].lease != 16'd0) && w_cell_q[0].joined &&
                        (w_cell_q[0].swarm == r_swarm);

    // slots rotate toward cell 0, the head output closes the ring
    for (genvar g = 0; g < plt_pkg::TABLE_SLOTS; g++) begin : g_cell
        if (g == plt_pkg::TABLE_SLOTS - 1) begin : g_tail
            plt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_walking),
                .i_slot  (w_feed),
                .o_slot  (w_cell_q[g])
            );
        end else begin : g_body
            plt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_walking),
                .i_slot  (w_cell_q[g+1]),
                .o_slot  (w_cell_q[g])
            );
        end
    end

    // query answer: earlier slots from the accumulator, last slot live
    logic r_q_ans;
    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_q_ans <= (r_state == plt_pkg::S_QUERY) &&
                       (w_acc_next.accepted || w_q_accept);
        end
    end

    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_active_node      = r_out_active;
    assign o_local_active     = r_out_local;
    assign o_active_changed   = r_out_changed;
    assign o_payload_accepted = r_q_ans & r_out_accepted | r_q_ans;

endmodule
